[hdl/u8d_pkg.sv]
package u8d_pkg;

    localparam int CpWidth  = 31;
    localparam int LenWidth = 3;

    typedef enum logic [1:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD,
        CLS_BAD
    } t_class;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_STRAY     = 3'd1,
        ST_INTERRUPT = 3'd2,
        ST_BAD_LEAD  = 3'd3,
        ST_TRUNC     = 3'd4
    } t_status;

    // classified input word as it waits in the queue
    typedef struct packed {
        t_class               cls;
        logic [LenWidth-1:0]  lead_len;
        logic [6:0]           bits;
        logic                 eot;
    } t_item;

    typedef struct packed {
        logic [CpWidth-1:0]   code_point;
        t_status              status;
        logic [LenWidth-1:0]  byte_length;
        logic                 last_of_run;
    } t_result;

    // outcome of a byte decoded with no sequence open
    typedef struct packed {
        logic                 valid;
        t_result              res;
        logic                 opens;
        logic [CpWidth-1:0]   partial;
        logic [LenWidth-1:0]  pending;
        logic [LenWidth-1:0]  seqlen;
    } t_fresh;

    // announced length of a lead byte, zero for 0xfe and 0xff
    function automatic logic [LenWidth-1:0] f_lead_length(input logic [7:0] b);
        logic [LenWidth-1:0] n;
        begin
            if (!b[5]) begin
                n = 3'd2;
            end else if (!b[4]) begin
                n = 3'd3;
            end else if (!b[3]) begin
                n = 3'd4;
            end else if (!b[2]) begin
                n = 3'd5;
            end else if (!b[1]) begin
                n = 3'd6;
            end else begin
                n = 3'd0;
            end
            return n;
        end
    endfunction

    function automatic t_item f_classify(input logic [7:0] b, input logic eot);
        t_item               it;
        logic [LenWidth-1:0] n;
        begin
            n           = f_lead_length(b);
            it.eot      = eot;
            it.lead_len = 3'd0;
            it.bits     = 7'd0;
            if (!b[7]) begin
                it.cls  = CLS_ASCII;
                it.bits = b[6:0];
            end else if (!b[6]) begin
                it.cls  = CLS_CONT;
                it.bits = {1'b0, b[5:0]};
            end else if (n == 3'd0) begin
                it.cls  = CLS_BAD;
            end else begin
                it.cls      = CLS_LEAD;
                it.lead_len = n;
                case (n)
                    3'd2:    it.bits = {2'b00, b[4:0]};
                    3'd3:    it.bits = {3'b000, b[3:0]};
                    3'd4:    it.bits = {4'b0000, b[2:0]};
                    3'd5:    it.bits = {5'b00000, b[1:0]};
                    default: it.bits = {6'b000000, b[0]};
                endcase
            end
            return it;
        end
    endfunction

    function automatic t_fresh f_fresh(input t_item it);
        t_fresh f;
        begin
            f                 = '0;
            f.res.last_of_run = 1'b1;
            f.res.byte_length = 3'd1;
            f.res.status      = ST_OK;
            case (it.cls)
                CLS_ASCII: begin
                    f.valid          = 1'b1;
                    f.res.code_point = CpWidth'(it.bits);
                end
                CLS_CONT: begin
                    f.valid      = 1'b1;
                    f.res.status = ST_STRAY;
                end
                CLS_BAD: begin
                    f.valid      = 1'b1;
                    f.res.status = ST_BAD_LEAD;
                end
                default: begin
                    if (it.eot) begin
                        f.valid      = 1'b1;
                        f.res.status = ST_TRUNC;
                    end else begin
                        f.opens   = 1'b1;
                        f.partial = CpWidth'(it.bits);
                        f.pending = it.lead_len - 3'd1;
                        f.seqlen  = it.lead_len;
                    end
                end
            endcase
            return f;
        end
    endfunction

endpackage

[hdl/u8d_in_if.sv]
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hdl/u8d_out_if.sv]
interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [2:0]  status;
    logic [2:0]  byte_length;
    logic        last_of_run;

    modport source (output valid, output code_point, output status, output byte_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input status, input byte_length,
                    input last_of_run, output ready);
endinterface

[hdl/u8d_front.sv]
module u8d_front (
    u8d_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output u8d_pkg::t_item  o_item
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;
    assign o_item     = u8d_pkg::f_classify(i_in.text_byte, i_in.end_of_text);

endmodule

[hdl/u8d_queue.sv]
module u8d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8d_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output u8d_pkg::t_item  o_item
);

    u8d_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

[hdl/u8d_back.sv]
module u8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  u8d_pkg::t_item  i_item,
    output logic            o_pop,
    u8d_out_if.source       o_out
);

    logic [2:0]       r_pending;
    logic [30:0]      r_partial;
    logic [2:0]       r_seqlen;
    logic             r_out_valid;
    u8d_pkg::t_result r_out;
    logic             r_hold_valid;
    u8d_pkg::t_result r_hold;

    logic [2:0]       n_pending;
    logic [30:0]      n_partial;
    logic [2:0]       n_seqlen;
    logic             n_out_valid;
    u8d_pkg::t_result n_out;
    logic             n_hold_valid;
    u8d_pkg::t_result n_hold;

    u8d_pkg::t_fresh  fr;
    u8d_pkg::t_result res0;
    u8d_pkg::t_result res1;
    logic [1:0]       cnt;
    logic [2:0]       d_pending;
    logic [30:0]      d_partial;
    logic [2:0]       d_seqlen;
    logic [30:0]      shifted;
    logic [2:0]       pend_dec;
    logic             out_free;

    // decode of the head word against the open sequence
    always_comb begin
        fr        = u8d_pkg::f_fresh(i_item);
        res0      = '0;
        res1      = '0;
        cnt       = 2'd0;
        d_pending = 3'd0;
        d_partial = '0;
        d_seqlen  = 3'd0;
        shifted   = {r_partial[24:0], i_item.bits[5:0]};
        pend_dec  = r_pending - 3'd1;
        if (r_pending == 3'd0) begin
            res0      = fr.res;
            cnt       = {1'b0, fr.valid};
            d_pending = fr.pending;
            d_partial = fr.partial;
            d_seqlen  = fr.seqlen;
        end else if (i_item.cls == u8d_pkg::CLS_CONT) begin
            res0.last_of_run = 1'b1;
            if (pend_dec == 3'd0) begin
                cnt              = 2'd1;
                res0.code_point  = shifted;
                res0.status      = u8d_pkg::ST_OK;
                res0.byte_length = r_seqlen;
            end else if (i_item.eot) begin
                cnt              = 2'd1;
                res0.status      = u8d_pkg::ST_TRUNC;
                res0.byte_length = r_seqlen - pend_dec;
            end else begin
                d_pending = pend_dec;
                d_partial = shifted;
                d_seqlen  = r_seqlen;
            end
        end else begin
            res0.status      = u8d_pkg::ST_INTERRUPT;
            res0.byte_length = r_seqlen - r_pending;
            res0.last_of_run = !fr.valid;
            res1             = fr.res;
            cnt              = fr.valid ? 2'd2 : 2'd1;
            d_pending        = fr.pending;
            d_partial        = fr.partial;
            d_seqlen         = fr.seqlen;
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_pending    = r_pending;
        n_partial    = r_partial;
        n_seqlen     = r_seqlen;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        o_pop        = 1'b0;
        if (r_hold_valid) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out        = r_hold;
                n_hold_valid = 1'b0;
            end
        end else if (i_q_valid && (cnt == 2'd0 || out_free)) begin
            o_pop     = 1'b1;
            n_pending = d_pending;
            n_partial = d_partial;
            n_seqlen  = d_seqlen;
            if (cnt != 2'd0) begin
                n_out_valid = 1'b1;
                n_out       = res0;
            end else if (out_free) begin
                n_out_valid = 1'b0;
            end
            if (cnt == 2'd2) begin
                n_hold_valid = 1'b1;
                n_hold       = res1;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 3'd0;
            r_partial    <= '0;
            r_seqlen     <= 3'd0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_pending    <= n_pending;
            r_partial    <= n_partial;
            r_seqlen     <= n_seqlen;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.code_point  = r_out.code_point;
    assign o_out.status      = r_out.status;
    assign o_out.byte_length = r_out.byte_length;
    assign o_out.last_of_run = r_out.last_of_run;

endmodule

[hdl/utf8_stream_decoder.sv]
// utf8 stream decoder: takes one byte of utf-8 text per word, with an end-of-text
// flag, and returns one result word per decoded code point or error. lead bytes
// announce 2 to 6 bytes (old long forms included); overlong forms and surrogates
// pass as they are. status: 0 ok, 1 stray continuation, 2 interrupted sequence
// (the interrupting byte is then decoded afresh, so one byte can give two
// results), 3 invalid lead 0xfe/0xff, 4 text ended mid-sequence. last_of_run
// marks the final result of each input byte. throughput is one byte per clock
// while the output is ready; a byte that yields two results holds the queue
// while its second result waits, as the single output register passes one
// result per clock. a byte runs through the queue and the output register to
// its first result. the front classifies bytes into a two-word queue, so input
// keeps flowing until it fills while a result waits. no clearing pass after reset.
module utf8_stream_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);

    // front to queue
    logic           push;
    u8d_pkg::t_item push_item;
    logic           q_full;

    // queue to back
    logic           q_valid;
    u8d_pkg::t_item q_item;
    logic           q_pop;

    // byte classification: ascii, continuation, lead with its length, invalid
    u8d_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    // short queue of classified words between front and back
    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // sequence state, result generation and output register
    u8d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

[verif/utf8_stream_decoder_tb.sv]
module utf8_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // idle cycles on both channels before the run is declared hung
    localparam int IdleLimit     = 2000;
    localparam int DirectedCount = 25;
    localparam int RandomCount   = 650;
    // spacing of the forced drain pauses in the random stream
    localparam int DrainSpacing  = 160;
    // cycles each receiver stall mode lasts before a new one is drawn
    localparam int ModeSpan      = 120;
    // extra cycles after the last expected word
    localparam int SettleCycles  = 8;

    // one text byte waiting to be driven
    typedef struct {
        logic [7:0] text_byte;
        logic       eot;
        logic       hold_for_drain;   // wait for all results before sending
    } t_text_word;

    // receiver stall modes
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN,
        RDY_BURSTY
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    utf8_stream_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // text bytes not yet driven, and result words not yet seen
    t_text_word       pending_bytes[$];
    u8d_pkg::t_result expected_results[$];

    // decoder state as the testbench tracks it
    logic [2:0]  seq_pending;
    logic [30:0] seq_value;
    logic [2:0]  seq_len;

    int   mismatch_cnt = 0;
    int   idle_cycles  = 0;
    logic timed_out    = 1'b0;
    logic byte_taken   = 1'b0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping
    t_stall_mode ready_mode  = RDY_ALWAYS;
    int          ready_phase = 0;
    int          stall_left  = 0;
    int          rx_tick     = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------

    function automatic void push_result(input logic [30:0] cp, input u8d_pkg::t_status st,
                                        input logic [2:0] len);
        u8d_pkg::t_result r;
        r.code_point  = cp;
        r.status      = st;
        r.byte_length = len;
        r.last_of_run = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    function automatic void clear_sequence();
        seq_pending = 3'd0;
        seq_value   = 31'd0;
        seq_len     = 3'd0;
    endfunction

    // number of leading one bits of a byte
    function automatic int count_lead_ones(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7-n])
            n++;
        return n;
    endfunction

    // byte taken with no sequence open
    function automatic void decode_fresh(input logic [7:0] b, input logic eot);
        int n;
        n = count_lead_ones(b);
        if (n == 0) begin
            push_result({24'd0, b[6:0]}, u8d_pkg::ST_OK, 3'd1);
        end else if (n == 1) begin
            push_result(31'd0, u8d_pkg::ST_STRAY, 3'd1);
        end else if (n >= 7) begin
            // 0xfe and 0xff
            push_result(31'd0, u8d_pkg::ST_BAD_LEAD, 3'd1);
        end else if (eot) begin
            // lead byte as the last byte of the text
            clear_sequence();
            push_result(31'd0, u8d_pkg::ST_TRUNC, 3'd1);
        end else begin
            seq_value   = 31'(b) & ((31'd1 << (7 - n)) - 31'd1);
            seq_pending = 3'(n - 1);
            seq_len     = 3'(n);
        end
    endfunction

    // expected result words for one accepted text byte
    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        int size_at_entry;
        size_at_entry = expected_results.size();
        if (seq_pending == 3'd0) begin
            decode_fresh(b, eot);
        end else if (b[7:6] == 2'b10) begin
            seq_value   = {seq_value[24:0], b[5:0]};
            seq_pending = seq_pending - 3'd1;
            if (seq_pending == 3'd0) begin
                push_result(seq_value, u8d_pkg::ST_OK, seq_len);
                clear_sequence();
            end else if (eot) begin
                // text ends with the sequence still open
                push_result(31'd0, u8d_pkg::ST_TRUNC, seq_len - seq_pending);
                clear_sequence();
            end
        end else begin
            // open sequence cut short, then the byte starts afresh
            push_result(31'd0, u8d_pkg::ST_INTERRUPT, seq_len - seq_pending);
            clear_sequence();
            decode_fresh(b, eot);
        end
        if (expected_results.size() > size_at_entry)
            expected_results[expected_results.size()-1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b, input logic eot);
        t_text_word w;
        w.text_byte      = b;
        w.eot            = eot;
        w.hold_for_drain = 1'b0;
        pending_bytes = {pending_bytes, w};
    endfunction

    // lead plus continuations of an n-byte sequence, the first emit_cnt of them
    function automatic void add_sequence(input int n, input int emit_cnt, input logic eot_last);
        logic [7:0] b;
        for (int k = 0; k < emit_cnt; k++) begin
            if (k == 0 && n == 1)
                b = 8'($urandom_range(0, 127));
            else if (k == 0)
                b = 8'((8'hff << (8 - n)) | $urandom_range(0, (1 << (7 - n)) - 1));
            else
                b = 8'h80 | 8'($urandom_range(0, 63));
            add_byte(b, eot_last && (k == emit_cnt - 1));
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: drives one text byte per word, in bursts with gaps
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        logic       nxt_valid;
        t_text_word w;
        nxt_valid = in_ch.valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!in_ch.valid || byte_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].hold_for_drain && expected_results.size() != 0)) begin
                w = pending_bytes.pop_front();
                in_ch.text_byte   <= w.text_byte;
                in_ch.end_of_text <= w.eot;
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // new burst; a quarter of the time no gap at all
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
        in_ch.valid <= nxt_valid;
    end

    // ------------------------------------------------------------------
    // receiver: ready follows a stall mode redrawn every ModeSpan cycles
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        logic nxt_ready;
        if (ready_phase == 0) begin
            ready_mode  = t_stall_mode'($urandom_range(0, 3));
            ready_phase = ModeSpan;
        end
        ready_phase--;
        rx_tick++;
        case (ready_mode)
            RDY_ALWAYS: begin
                nxt_ready = 1'b1;
            end
            RDY_RANDOM: begin
                nxt_ready = ($urandom_range(0, 3) != 0);
            end
            RDY_PATTERN: begin
                // ready two fifths of the time, in a repeating pattern
                nxt_ready = ((rx_tick % 5) < 2);
            end
            default: begin
                // long stalls now and then
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_ready = 1'b0;
                end else begin
                    nxt_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(3, 12);
                end
            end
        endcase
        out_ch.ready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // monitor: checks result words, predicts from accepted text bytes
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        u8d_pkg::t_result want;
        logic             in_fire;
        logic             out_fire;
        in_fire  = i_rst_n && in_ch.valid && in_ch.ready;
        out_fire = i_rst_n && out_ch.valid && out_ch.ready;
        if (out_fire) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: cp=%h st=%0d len=%0d",
                                          out_ch.code_point, out_ch.status,
                                          out_ch.byte_length));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, want %h",
                                              out_ch.code_point, want.code_point));
                if (out_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %s",
                                              out_ch.status, want.status.name()));
                if (out_ch.byte_length !== want.byte_length)
                    report_mismatch($sformatf("byte_length %0d, want %0d",
                                              out_ch.byte_length, want.byte_length));
                if (out_ch.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              out_ch.last_of_run, want.last_of_run));
            end
        end
        // predict after the check so a stray early word cannot match
        if (in_fire)
            decode_byte(in_ch.text_byte, in_ch.end_of_text);
        // watchdog on cycles with no word moving either way
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IdleLimit) begin
                $display("[%0t] watchdog: no word moved for %0d cycles", $time, IdleLimit);
                timed_out <= 1'b1;
            end
        end
        byte_taken <= in_fire;
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial begin
        int         pick;
        int         n;
        int         cut;
        int         next_hold_at;
        logic [7:0] b;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.text_byte   = 8'd0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        clear_sequence();

        // directed: ascii extremes, stray continuations, invalid leads
        add_byte(8'h00, 1'b0);
        add_byte(8'h7f, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hbf, 1'b1);
        add_byte(8'hfe, 1'b0);
        add_byte(8'hff, 1'b1);
        // two- and four-byte sequences
        add_byte(8'hc2, 1'b0);
        add_byte(8'ha9, 1'b0);
        add_byte(8'hf0, 1'b0);
        add_byte(8'h9f, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b0);
        // six-byte form with every payload bit set, the largest code point
        add_byte(8'hfd, 1'b0);
        repeat (5) add_byte(8'hbf, 1'b0);
        // interrupted by a lead that ends the text: two results from one byte
        add_byte(8'he2, 1'b0);
        add_byte(8'hc3, 1'b1);
        // interrupted by ascii after two bytes
        add_byte(8'he2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'h41, 1'b0);
        // text ends mid-sequence
        add_byte(8'he2, 1'b0);
        add_byte(8'h82, 1'b1);

        // random: mostly well-formed sequences, some broken ones and noise
        next_hold_at = DirectedCount + 1;
        while (pending_bytes.size() < DirectedCount + RandomCount) begin
            pick = $urandom_range(0, 99);
            n    = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
            if (pick < 68) begin
                add_sequence(n, n, $urandom_range(0, 9) == 0);
            end else if (pick < 78) begin
                n   = $urandom_range(2, 6);
                cut = $urandom_range(1, n - 1);
                if ($urandom_range(0, 1) == 0) begin
                    // truncated by end of text
                    add_sequence(n, cut, 1'b1);
                end else begin
                    // interrupted by any byte but a continuation
                    add_sequence(n, cut, 1'b0);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b[7:6] == 2'b10);
                    add_byte(b, $urandom_range(0, 3) == 0);
                end
            end else if (pick < 85) begin
                add_byte(8'($urandom_range(8'h80, 8'hbf)), $urandom_range(0, 3) == 0);
            end else if (pick < 89) begin
                add_byte(8'($urandom_range(8'hfe, 8'hff)), $urandom_range(0, 3) == 0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            // sender pauses here until every pending result is out
            if (pending_bytes.size() >= next_hold_at) begin
                pending_bytes[pending_bytes.size()-1].hold_for_drain = 1'b1;
                next_hold_at += DrainSpacing;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all text bytes accepted
        do
            @(negedge i_clk);
        while ((pending_bytes.size() != 0 || in_ch.valid) && !timed_out);
        // all results seen
        while (expected_results.size() != 0 && !timed_out)
            @(negedge i_clk);
        // catch any extra result words
        repeat (SettleCycles) @(negedge i_clk);

        if (timed_out || mismatch_cnt != 0)
            $display("Testbench completed WITH ERRORS");
        else
            $display("Testbench completed without errors");
        $finish;
    end

endmodule

[filelist.f]
hdl/u8d_pkg.sv
hdl/u8d_in_if.sv
hdl/u8d_out_if.sv
hdl/u8d_front.sv
hdl/u8d_queue.sv
hdl/u8d_back.sv
hdl/utf8_stream_decoder.sv
verif/utf8_stream_decoder_tb.sv
